// ===== rtl/rps_pkg.sv =====
// Package for the postponed-refresh scheduler: field widths, request,
// command and register codes, and the control/status structs.
// No dependencies.
package rps_pkg;

  localparam int unsigned REQ_W      = 3;
  localparam int unsigned RANK_W     = 2;
  localparam int unsigned BANK_W     = 3;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned GSL_W      = 2;
  localparam int unsigned GTS_W      = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // request types
  localparam logic [REQ_W-1:0] REQ_PULSE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SCHED = 3'd1;
  localparam logic [REQ_W-1:0] REQ_OPEN  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLOSE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DONE  = 3'd4;

  // command kinds on the result channel
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REF  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REF_EN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_EN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRP_LOG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN    = 3'd4;

  typedef struct packed {
    logic accept;   // latch the new transaction
    logic simple;   // execute a non-schedule request
    logic scan;     // examine one group
    logic pre;      // step one bank of the hit group
    logic refresh;  // emit the refresh
    logic miss;     // emit the empty schedule result
  } rps_cmd_t;

  typedef struct packed {
    logic in_sched;   // incoming transaction is a schedule attempt
    logic hit;        // current group needs refresh
    logic scan_done;  // no hit and nothing left to scan
    logic pre_emit;   // current bank takes a precharge
    logic pre_last;   // current bank is the last of the group
    logic out_free;   // output register can be loaded
  } rps_stat_t;

endpackage

// ===== rtl/rps_if.sv =====
// Channel interfaces of the postponed-refresh scheduler: request, result
// and configuration write. Depends on rps_pkg.
interface rps_in_if;
  logic                         valid;
  logic                         ready;
  logic [rps_pkg::REQ_W-1:0]    req_type;
  logic [rps_pkg::RANK_W-1:0]   rank;
  logic [rps_pkg::BANK_W-1:0]   bank;
  modport source (output valid, req_type, rank, bank, input ready);
  modport sink   (input valid, req_type, rank, bank, output ready);
endinterface

interface rps_out_if;
  logic                         valid;
  logic                         ready;
  logic [rps_pkg::KIND_W-1:0]   cmd_kind;
  logic [rps_pkg::RANK_W-1:0]   cmd_rank;
  logic [rps_pkg::BANK_W-1:0]   cmd_bank;
  logic                         scheduled;
  logic                         bank_needs_refresh;
  logic                         bank_refresh_queued;
  logic                         last;
  modport source (output valid, cmd_kind, cmd_rank, cmd_bank, scheduled,
                  bank_needs_refresh, bank_refresh_queued, last, input ready);
  modport sink   (input valid, cmd_kind, cmd_rank, cmd_bank, scheduled,
                  bank_needs_refresh, bank_refresh_queued, last, output ready);
endinterface

interface rps_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rps_pkg::CFG_IDX_W-1:0]   index;
  logic [rps_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/rps_ctrl.sv =====
// Sequencer of the postponed-refresh scheduler: steps a transaction through
// execute, scan, precharge and refresh or miss phases. Depends on rps_pkg.
module rps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rps_pkg::rps_stat_t stat,
  output rps_pkg::rps_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SIMPLE = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_PRE    = 6'b001000,
    ST_REF    = 6'b010000,
    ST_MISS   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.in_sched ? ST_SCAN : ST_SIMPLE;
        end
      end
      ST_SIMPLE: begin
        if (stat.out_free) begin
          cmd.simple = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          state_nxt = ST_PRE;
        end else if (stat.scan_done) begin
          state_nxt = ST_MISS;
        end
      end
      ST_PRE: begin
        // hold while a precharge waits for the output register
        if (!stat.pre_emit || stat.out_free) begin
          cmd.pre = 1'b1;
          if (stat.pre_last) begin
            state_nxt = ST_REF;
          end
        end
      end
      ST_REF: begin
        if (stat.out_free) begin
          cmd.refresh = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_MISS: begin
        if (stat.out_free) begin
          cmd.miss  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/rps_dp.sv =====
// Datapath of the postponed-refresh scheduler: configuration registers,
// per-group counters, bank marks, scan pointers and the output register.
// Depends on rps_pkg; driven by rps_ctrl.
module rps_dp #(
  parameter int unsigned NUM_RANKS   = 4,
  parameter int unsigned NUM_BANKS   = 8,
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rps_pkg::rps_cmd_t                cmd,
  output rps_pkg::rps_stat_t               stat,
  input  logic [rps_pkg::REQ_W-1:0]        in_req_type,
  input  logic [rps_pkg::RANK_W-1:0]       in_rank,
  input  logic [rps_pkg::BANK_W-1:0]       in_bank,
  input  logic                             cfg_valid,
  input  logic [rps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rps_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [rps_pkg::KIND_W-1:0]       out_cmd_kind,
  output logic [rps_pkg::RANK_W-1:0]       out_cmd_rank,
  output logic [rps_pkg::BANK_W-1:0]       out_cmd_bank,
  output logic                             out_scheduled,
  output logic                             out_need,
  output logic                             out_queued,
  output logic                             out_last
);

  localparam int unsigned RW    = (NUM_RANKS > 1) ? $clog2(NUM_RANKS) : 1;
  localparam int unsigned BW    = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int unsigned NSLOT = NUM_RANKS * NUM_BANKS;
  localparam int unsigned SW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int unsigned SUMW  = BW + 4;
  localparam int unsigned CMW   = (COUNT_WIDTH > rps_pkg::THR_W) ?
                                  COUNT_WIDTH : rps_pkg::THR_W;
  localparam int unsigned NGW   = $clog2(NUM_BANKS + 1);
  localparam int unsigned SLW   = (NGW > rps_pkg::GTS_W) ? NGW : rps_pkg::GTS_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  function automatic logic [SW-1:0] slot_of(input logic [RW-1:0] r,
                                             input logic [BW-1:0] b);
    return SW'(int'(r) * NUM_BANKS + int'(b));
  endfunction

  // (v mod NUM_BANKS) for v below NUM_BANKS + 8
  function automatic logic [BW-1:0] mod_nb(input logic [SUMW-1:0] v);
    logic [SUMW-1:0] x;
    x = v;
    for (int n = 0; n < 8; n++) begin
      if (x >= SUMW'(NUM_BANKS)) x = x - SUMW'(NUM_BANKS);
    end
    return BW'(x);
  endfunction

  // configuration
  logic                         ref_en_r, pre_en_r;
  logic [rps_pkg::THR_W-1:0]    thr_r;
  logic [rps_pkg::GSL_W-1:0]    gsl_r;
  logic [rps_pkg::GTS_W-1:0]    gts_r;

  // state
  logic [COUNT_WIDTH-1:0] count_r [NSLOT];
  logic [NSLOT-1:0]       need_r, queued_r, open_r;
  logic [BW-1:0]          nbp_r;
  logic [RW-1:0]          nrp_r;

  // transaction and scan registers
  logic [rps_pkg::REQ_W-1:0]  req_type_r;
  logic [rps_pkg::RANK_W-1:0] req_rank_r;
  logic [rps_pkg::BANK_W-1:0] req_bank_r;
  logic [RW-1:0]              rank_i_r;
  logic [BW-1:0]              bank_j_r;
  logic [RW-1:0]              r_cnt_r;
  logic [SLW-1:0]             k_cnt_r;
  logic [2:0]                 t_r;
  logic                       out_valid_r;

  // combinational
  logic [3:0]              gsize;
  logic [NGW+3:0]          ng_sum;
  logic [NGW-1:0]          ngroups;
  logic [SLW-1:0]          scan_len;
  logic                    req_ok, sel_ok, is_sched;
  logic [SW-1:0]           req_slot;
  logic [RW-1:0]           sel_rank;
  logic [BW-1:0]           sel_bank, sel_grp, sel_head;
  logic [SW-1:0]           cnt_addr;
  logic [COUNT_WIDTH-1:0]  cnt_cur, cnt_inc, cnt_dec;
  logic                    needs_cur, needs_inc, needs_dec;
  logic [NSLOT-1:0]        grp_mask;
  logic [SUMW-1:0]         msum;
  logic                    hit, k_last, r_last;
  logic [BW-1:0]           j_adv;
  logic [RW-1:0]           i_adv;
  logic [SUMW-1:0]         b_sum, np_sum;
  logic [BW-1:0]           b_idx;
  logic [SW-1:0]           b_slot, h_slot;
  logic                    pre_emit, out_free, out_load;
  logic                    s_need, s_queued;

  assign gsize    = 4'(1) << gsl_r;
  assign ng_sum   = (NGW+4)'(NUM_BANKS) + (NGW+4)'(gsize) - (NGW+4)'(1);
  assign ngroups  = NGW'(ng_sum >> gsl_r);
  assign scan_len = (SLW'(gts_r) < SLW'(ngroups)) ? SLW'(gts_r) : SLW'(ngroups);

  assign is_sched = (req_type_r == rps_pkg::REQ_SCHED);
  assign req_ok   = (int'(req_rank_r) < NUM_RANKS) && (int'(req_bank_r) < NUM_BANKS);
  assign req_slot = slot_of(RW'(req_rank_r), BW'(req_bank_r));

  // group addressed by the request, or by the scan position
  assign sel_rank = is_sched ? rank_i_r : RW'(req_rank_r);
  assign sel_bank = is_sched ? bank_j_r : BW'(req_bank_r);
  assign sel_ok   = is_sched ? 1'b1 : req_ok;
  assign sel_grp  = sel_bank >> gsl_r;
  assign sel_head = sel_grp << gsl_r;
  assign cnt_addr = slot_of(sel_rank, sel_grp);
  assign cnt_cur  = count_r[cnt_addr];
  assign cnt_inc  = (cnt_cur != CNT_MAX) ? cnt_cur + COUNT_WIDTH'(1) : cnt_cur;
  assign cnt_dec  = (cnt_cur != '0) ? cnt_cur - COUNT_WIDTH'(1) : cnt_cur;
  assign needs_cur = ref_en_r && (CMW'(cnt_cur) >= CMW'(thr_r));
  assign needs_inc = ref_en_r && (CMW'(cnt_inc) >= CMW'(thr_r));
  assign needs_dec = ref_en_r && (CMW'(cnt_dec) >= CMW'(thr_r));

  always_comb begin
    grp_mask = '0;
    msum     = '0;
    for (int t = 0; t < 8; t++) begin
      msum = SUMW'(sel_head) + SUMW'(t);
      if (sel_ok && (4'(t) < gsize) && (msum < SUMW'(NUM_BANKS))) begin
        grp_mask[slot_of(sel_rank, BW'(msum))] = 1'b1;
      end
    end
  end

  // scan walk
  assign hit    = (scan_len != '0) && needs_cur;
  assign k_last = ((SLW+1)'(k_cnt_r) + (SLW+1)'(1)) >= (SLW+1)'(scan_len);
  assign r_last = (r_cnt_r == RW'(NUM_RANKS - 1));
  assign j_adv  = mod_nb(SUMW'(bank_j_r) + SUMW'(gsize));
  assign i_adv  = (rank_i_r == RW'(NUM_RANKS - 1)) ? '0 : rank_i_r + RW'(1);
  assign np_sum = SUMW'(nbp_r) + SUMW'(gsize);

  // precharge walk over the hit group
  assign b_sum    = SUMW'(sel_head) + SUMW'(t_r);
  assign b_idx    = BW'(b_sum);
  assign b_slot   = slot_of(rank_i_r, b_idx);
  assign h_slot   = slot_of(rank_i_r, sel_head);
  assign pre_emit = pre_en_r && (b_sum < SUMW'(NUM_BANKS)) && open_r[b_slot];

  assign out_free = !out_valid_r || out_ready;
  assign out_load = cmd.simple || cmd.refresh || cmd.miss || (cmd.pre && pre_emit);

  // marks of the addressed bank after a non-schedule request
  always_comb begin
    s_need   = 1'b0;
    s_queued = 1'b0;
    if (req_ok) begin
      s_need   = need_r[req_slot];
      s_queued = queued_r[req_slot];
      if (req_type_r == rps_pkg::REQ_PULSE && needs_inc) s_need = 1'b1;
      if (req_type_r == rps_pkg::REQ_DONE) s_queued = 1'b0;
    end
  end

  always_comb begin
    stat           = '0;
    stat.in_sched  = (in_req_type == rps_pkg::REQ_SCHED);
    stat.hit       = hit;
    stat.scan_done = !hit && k_last && r_last;
    stat.pre_emit  = pre_emit;
    stat.pre_last  = (t_r == 3'(gsize - 4'(1)));
    stat.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_en_r    <= 1'b1;
      pre_en_r    <= 1'b1;
      thr_r       <= rps_pkg::THR_W'(1);
      gsl_r       <= '0;
      gts_r       <= rps_pkg::GTS_W'(8);
      for (int s = 0; s < NSLOT; s++) count_r[s] <= '0;
      need_r      <= '0;
      queued_r    <= '0;
      open_r      <= '0;
      nbp_r       <= '0;
      nrp_r       <= '0;
      req_type_r  <= '0;
      req_rank_r  <= '0;
      req_bank_r  <= '0;
      rank_i_r    <= '0;
      bank_j_r    <= '0;
      r_cnt_r     <= '0;
      k_cnt_r     <= '0;
      t_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          rps_pkg::CFG_REF_EN:  ref_en_r <= cfg_data[0];
          rps_pkg::CFG_PRE_EN:  pre_en_r <= cfg_data[0];
          rps_pkg::CFG_THRESH:  thr_r    <= cfg_data;
          rps_pkg::CFG_GRP_LOG: gsl_r    <= cfg_data[rps_pkg::GSL_W-1:0];
          rps_pkg::CFG_SCAN:    gts_r    <= cfg_data[rps_pkg::GTS_W-1:0];
          default: ;
        endcase
      end

      if (cmd.accept) begin
        req_type_r <= in_req_type;
        req_rank_r <= in_rank;
        req_bank_r <= in_bank;
        rank_i_r   <= nrp_r;
        bank_j_r   <= nbp_r;
        r_cnt_r    <= '0;
        k_cnt_r    <= '0;
      end

      if (cmd.simple && req_ok) begin
        case (req_type_r)
          rps_pkg::REQ_PULSE: begin
            count_r[cnt_addr] <= cnt_inc;
            if (needs_inc) need_r <= need_r | grp_mask;
          end
          rps_pkg::REQ_OPEN:  open_r[req_slot] <= 1'b1;
          rps_pkg::REQ_CLOSE: open_r[req_slot] <= 1'b0;
          rps_pkg::REQ_DONE:  queued_r <= queued_r & ~grp_mask;
          default: ;
        endcase
      end

      if (cmd.scan) begin
        if (hit) begin
          count_r[cnt_addr] <= cnt_dec;
          queued_r <= queued_r | grp_mask;
          if (!needs_dec) need_r <= need_r & ~grp_mask;
          t_r <= '0;
          if (np_sum >= SUMW'(NUM_BANKS)) begin
            nbp_r <= '0;
            nrp_r <= (nrp_r == RW'(NUM_RANKS - 1)) ? '0 : nrp_r + RW'(1);
          end else begin
            nbp_r <= BW'(np_sum);
          end
        end else if (k_last) begin
          // next rank restarts at the bank pointer
          k_cnt_r  <= '0;
          r_cnt_r  <= r_cnt_r + RW'(1);
          rank_i_r <= i_adv;
          bank_j_r <= nbp_r;
        end else begin
          k_cnt_r  <= k_cnt_r + SLW'(1);
          bank_j_r <= j_adv;
        end
      end

      if (cmd.pre) begin
        if (pre_emit) open_r[b_slot] <= 1'b0;
        t_r <= t_r + 3'(1);
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.simple || cmd.miss) begin
      out_cmd_kind  <= rps_pkg::KIND_NONE;
      out_cmd_rank  <= '0;
      out_cmd_bank  <= '0;
      out_scheduled <= 1'b0;
      out_need      <= cmd.simple ? s_need : 1'b0;
      out_queued    <= cmd.simple ? s_queued : 1'b0;
      out_last      <= 1'b1;
    end else if (cmd.pre && pre_emit) begin
      out_cmd_kind  <= rps_pkg::KIND_PRE;
      out_cmd_rank  <= rps_pkg::RANK_W'(rank_i_r);
      out_cmd_bank  <= rps_pkg::BANK_W'(b_idx);
      out_scheduled <= 1'b1;
      out_need      <= need_r[b_slot];
      out_queued    <= queued_r[b_slot];
      out_last      <= 1'b0;
    end else if (cmd.refresh) begin
      out_cmd_kind  <= rps_pkg::KIND_REF;
      out_cmd_rank  <= rps_pkg::RANK_W'(rank_i_r);
      out_cmd_bank  <= rps_pkg::BANK_W'(sel_head);
      out_scheduled <= 1'b1;
      out_need      <= need_r[h_slot];
      out_queued    <= queued_r[h_slot];
      out_last      <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/refresh_postpone_scheduler.sv =====
// Top level of the postponed-refresh scheduler: joins sequencer and datapath
// to the request, result and configuration channels.
// Depends on rps_pkg, rps_if, rps_ctrl and rps_dp.
//
//  channel  dir  fields                                        transaction
//  in_ch    in   req_type, rank, bank                           valid & ready
//  out_ch   out  cmd_kind, cmd_rank, cmd_bank, scheduled,       valid & ready
//                bank_needs_refresh, bank_refresh_queued, last
//  cfg_ch   in   index, data                                    valid & ready
//
// One transaction at a time. A non-schedule request is accepted, then executed.
// A schedule attempt is accepted and scans groups, one group per cycle through
// the counter read port, up to NUM_RANKS * scan length (one per rank when the
// scan length is zero), then group size precharge steps on a hit, and a result.
// cfg_ch is always ready.
// A stalled result holds the sequencer in place; the next request is taken
// while the last result still waits. Reset clears all marks and counters.
module refresh_postpone_scheduler #(
  parameter int unsigned NUM_RANKS   = 4,
  parameter int unsigned NUM_BANKS   = 8,
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  rps_in_if.sink     in_ch,
  rps_out_if.source  out_ch,
  rps_cfg_if.sink    cfg_ch
);

  rps_pkg::rps_cmd_t  cmd;
  rps_pkg::rps_stat_t stat;
  logic               in_ready;

  rps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rps_dp #(
    .NUM_RANKS   (NUM_RANKS),
    .NUM_BANKS   (NUM_BANKS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_req_type   (in_ch.req_type),
    .in_rank       (in_ch.rank),
    .in_bank       (in_ch.bank),
    .cfg_valid     (cfg_ch.valid),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_cmd_kind  (out_ch.cmd_kind),
    .out_cmd_rank  (out_ch.cmd_rank),
    .out_cmd_bank  (out_ch.cmd_bank),
    .out_scheduled (out_ch.scheduled),
    .out_need      (out_ch.bank_needs_refresh),
    .out_queued    (out_ch.bank_refresh_queued),
    .out_last      (out_ch.last)
  );

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

endmodule
